// ===== rtl/mqd_pkg.sv =====
// Shared types, field widths and codes for the multi-queue deque engine.
package mqd_pkg;

  localparam int unsigned NUM_QUEUES_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  localparam int unsigned QSEL_W     = 5;
  localparam int unsigned ENTRY_ID_W = 16;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned QCNT_W     = 4;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [CODE_W-1:0] RC_ADDED = 2'd0;
  localparam logic [CODE_W-1:0] RC_FULL  = 2'd1;
  localparam logic [CODE_W-1:0] RC_TAKEN = 2'd2;
  localparam logic [CODE_W-1:0] RC_EMPTY = 2'd3;

  typedef struct packed {
    logic                  mode;
    logic [QSEL_W-1:0]     queue_select;
    logic [ENTRY_ID_W-1:0] entry_id;
    logic                  urgent;
  } mqd_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]     result_code;
    logic [ENTRY_ID_W-1:0] taken_id;
    logic [QCNT_W-1:0]     queue_count;
  } mqd_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;          // latch request, read queue state
    logic commit;          // write back queue state and entry, or read entry
    logic load_out;        // load output register
    logic out_from_fetch;  // output comes from the entry read
  } mqd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic take_hit;        // take on a non-empty queue, needs an entry read
  } mqd_status_t;

endpackage

// ===== rtl/multi_queue_deque_engine.sv =====
// Top level of the multi-queue deque engine.
// Keeps NUM_QUEUES bounded queues of up to QUEUE_DEPTH entry IDs each, every queue a ring
// addressed by a head pointer and a fill count held in a small state RAM, with the IDs in
// one entry RAM of NUM_QUEUES * QUEUE_DEPTH words. A request beat is accepted only while
// the engine is idle. Adds, rejected adds and takes from an empty or absent queue finish
// with a state RAM read, then a write back; a successful take also needs an entry RAM read,
// issued at the head pointer only after the state RAM read returns it.
// A stalled output adds its stall cycles. The next request is accepted while a result
// beat is still waiting on the output. No clearing pass is run after reset: queue state
// carries a valid bit per queue, so every queue starts empty at once.
module multi_queue_deque_engine #(
  parameter int unsigned NUM_QUEUES  = mqd_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = mqd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = mqd_pkg::ID_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mqd_pkg::mqd_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mqd_pkg::mqd_rsp_t out_rsp_o
);
  import mqd_pkg::*;

  mqd_cmd_t    cmd;
  mqd_status_t status;

  mqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mqd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o),
    .cmd_i     (cmd),
    .status_o  (status)
  );

endmodule

// ===== rtl/mqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mqd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data when no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/mqd_ctrl.sv =====
// Sequencing state machine and output handshake of the multi-queue deque engine.
module mqd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mqd_pkg::mqd_cmd_t   cmd_o,
  input  mqd_pkg::mqd_status_t status_i
);
  import mqd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_FETCH  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (status_i.take_hit) begin
          cmd_o.commit = 1'b1;
          state_d      = S_FETCH;
        end else if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          cmd_o.load_out       = 1'b1;
          cmd_o.out_from_fetch = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new beat appears only out of a lookup or an entry fetch
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_LOOKUP || $past(state_q) == S_FETCH))
    else $error("output beat without a finished request");

  // An entry fetch always follows a lookup that committed a take
  a_fetch_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH && $past(state_q) != S_FETCH) |->
      ($past(state_q) == S_LOOKUP && $past(status_i.take_hit)))
    else $error("fetch entered without a take");

  // A waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.load_out)
    else $error("output register overwritten while stalled");

endmodule

// ===== rtl/mqd_datapath.sv =====
// Queue state and entry memories, ring pointer arithmetic and output register.
module mqd_datapath #(
  parameter int unsigned NUM_QUEUES  = mqd_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = mqd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = mqd_pkg::ID_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mqd_pkg::mqd_req_t    in_req_i,
  output mqd_pkg::mqd_rsp_t    out_rsp_o,
  input  mqd_pkg::mqd_cmd_t    cmd_i,
  output mqd_pkg::mqd_status_t status_o
);
  import mqd_pkg::*;

  localparam int unsigned QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = PTR_W + 1;
  localparam int unsigned SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] count;
  } qstate_t;

  localparam int unsigned ST_W = $bits(qstate_t);

  mqd_req_t            req_q;
  mqd_rsp_t            rsp_q;
  logic [QCNT_W-1:0]   take_cnt_q;
  logic [NUM_QUEUES-1:0] st_vld_q, st_vld_d;

  logic [31:0]         q_ext_in, q_ext;
  logic [QIDX_W-1:0]   qidx_in, qidx;
  logic                in_range;
  logic                st_vld;
  logic [ST_W-1:0]     st_rd_raw;
  qstate_t             st_rd, st_cur, st_new;
  logic                is_take, full, empty, add_ok, take_ok;
  logic [PTR_W-1:0]    head_dec, head_inc, tail_pos, wr_pos;
  logic [SUM_W-1:0]    tail_sum;
  logic [SLOT_W-1:0]   slot_base, wr_slot, rd_slot;
  logic [63:0]         id_in_ext, id_out_ext;
  logic [ID_WIDTH-1:0] ent_rd;
  logic [31:0]         cnt_ext;
  logic [QCNT_W-1:0]   cnt_out;
  logic [CODE_W-1:0]   code;
  logic                st_we, ent_we, ent_re;

  assign q_ext_in = 32'(in_req_i.queue_select);
  assign qidx_in  = q_ext_in[QIDX_W-1:0];
  assign q_ext    = 32'(req_q.queue_select);
  assign qidx     = q_ext[QIDX_W-1:0];
  assign in_range = q_ext < NUM_QUEUES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
  end

  mqd_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_QUEUES)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (st_we),
    .wr_addr_i (qidx),
    .wr_data_i (st_new),
    .rd_en_i   (cmd_i.accept),
    .rd_addr_i (qidx_in),
    .rd_data_o (st_rd_raw)
  );

  // A queue never written reads as empty with its head at zero
  assign st_rd  = st_rd_raw;
  assign st_vld = in_range && st_vld_q[qidx];
  assign st_cur = st_vld ? st_rd : '0;

  assign is_take = (req_q.mode == MODE_TAKE);
  assign full    = st_cur.count >= CNT_W'(QUEUE_DEPTH);
  assign empty   = st_cur.count == '0;
  assign add_ok  = in_range && !is_take && !full;
  assign take_ok = in_range && is_take && !empty;

  assign head_dec = (st_cur.head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : st_cur.head - 1'b1;
  assign head_inc = (st_cur.head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : st_cur.head + 1'b1;

  // Count is below depth on a successful add, so one subtract wraps the tail
  assign tail_sum = SUM_W'(st_cur.head) + SUM_W'(st_cur.count);
  assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                  ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign wr_pos   = req_q.urgent ? head_dec : tail_pos;

  always_comb begin
    st_new = st_cur;
    if (add_ok) begin
      st_new.count = st_cur.count + 1'b1;
      if (req_q.urgent) begin
        st_new.head = head_dec;
      end
    end else if (take_ok) begin
      st_new.count = st_cur.count - 1'b1;
      st_new.head  = head_inc;
    end
  end

  assign slot_base = SLOT_W'(SLOT_W'(qidx) * SLOT_W'(QUEUE_DEPTH));
  assign wr_slot   = SLOT_W'(slot_base + SLOT_W'(wr_pos));
  assign rd_slot   = SLOT_W'(slot_base + SLOT_W'(st_cur.head));

  assign st_we  = cmd_i.commit && (add_ok || take_ok);
  assign ent_we = cmd_i.commit && add_ok;
  assign ent_re = cmd_i.commit && take_ok;

  assign id_in_ext = 64'(req_q.entry_id);

  mqd_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ent_we),
    .wr_addr_i (wr_slot),
    .wr_data_i (id_in_ext[ID_WIDTH-1:0]),
    .rd_en_i   (ent_re),
    .rd_addr_i (rd_slot),
    .rd_data_o (ent_rd)
  );

  assign id_out_ext = 64'(ent_rd);

  always_comb begin
    st_vld_d = st_vld_q;
    if (st_we) begin
      st_vld_d[qidx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else begin
      st_vld_q <= st_vld_d;
    end
  end

  assign cnt_ext = 32'(st_new.count);
  assign cnt_out = in_range ? cnt_ext[QCNT_W-1:0] : '0;

  always_comb begin
    if (is_take) begin
      code = take_ok ? RC_TAKEN : RC_EMPTY;
    end else begin
      code = add_ok ? RC_ADDED : RC_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_re) begin
      take_cnt_q <= cnt_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.out_from_fetch) begin
        rsp_q.result_code <= RC_TAKEN;
        rsp_q.taken_id    <= id_out_ext[ENTRY_ID_W-1:0];
        rsp_q.queue_count <= take_cnt_q;
      end else begin
        rsp_q.result_code <= code;
        rsp_q.taken_id    <= '0;
        rsp_q.queue_count <= cnt_out;
      end
    end
  end

  assign out_rsp_o         = rsp_q;
  assign status_o.take_hit = take_ok;

  // Entry memory sees either an add or a take in one commit, never both
  a_one_entry_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ent_we && ent_re))
    else $error("entry write and read in the same commit");

  // A written queue state never holds more entries than the ring has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (st_new.count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

endmodule

// ===== verif/tb_multi_queue_deque_engine.sv =====
// Self-checking testbench for the multi-queue deque engine: directed and random traffic.
module tb_multi_queue_deque_engine;
  import mqd_pkg::*;

  localparam int unsigned NUM_Q       = NUM_QUEUES_DEF;
  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_PRINTS  = 40;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  mqd_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mqd_rsp_t out_rsp_o;

  // Predicted queue state; every queue starts empty with its head at zero
  logic [ENTRY_ID_W-1:0] ring_id   [NUM_Q][DEPTH];
  logic [PTR_W-1:0]      ring_head [NUM_Q] = '{default: '0};
  logic [QCNT_W-1:0]     ring_fill [NUM_Q] = '{default: '0};

  mqd_rsp_t    pending_rsp_q[$];
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_off_left = 0;
  bit          tx_jitter     = 1'b1;
  bit          rx_jitter     = 1'b1;

  multi_queue_deque_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multi_queue_deque_engine NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  function automatic mqd_rsp_t deque_predict(input mqd_req_t req);
    mqd_rsp_t       rsp;
    int unsigned    q;
    logic [PTR_W-1:0] slot;
    rsp = '0;
    q   = 32'(req.queue_select);
    if (q >= NUM_Q) begin
      // absent queue: answer without touching state
      rsp.result_code = (req.mode == MODE_TAKE) ? RC_EMPTY : RC_FULL;
    end else if (req.mode == MODE_ADD) begin
      if (ring_fill[q] >= DEPTH) begin
        rsp.result_code = RC_FULL;
        rsp.queue_count = ring_fill[q];
      end else begin
        if (req.urgent) begin
          ring_head[q] = ring_head[q] - 1'b1;
          slot         = ring_head[q];
        end else begin
          slot = ring_head[q] + ring_fill[q][PTR_W-1:0];
        end
        ring_id[q][slot] = req.entry_id;
        ring_fill[q]     = ring_fill[q] + 1'b1;
        rsp.result_code  = RC_ADDED;
        rsp.queue_count  = ring_fill[q];
      end
    end else begin
      if (ring_fill[q] == 0) begin
        rsp.result_code = RC_EMPTY;
      end else begin
        rsp.taken_id    = ring_id[q][ring_head[q]];
        ring_head[q]    = ring_head[q] + 1'b1;
        ring_fill[q]    = ring_fill[q] - 1'b1;
        rsp.result_code = RC_TAKEN;
        rsp.queue_count = ring_fill[q];
      end
    end
    return rsp;
  endfunction

  function automatic mqd_req_t mk_req(input logic mode, input int unsigned q,
                                      input int unsigned id, input logic urg);
    mqd_req_t req;
    req.mode         = mode;
    req.queue_select = QSEL_W'(q);
    req.entry_id     = ENTRY_ID_W'(id);
    req.urgent       = urg;
    return req;
  endfunction

  // Receiver: random stalls, a counted hold-off when requested, or always ready
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_jitter) begin
      out_ready_i <= ($urandom_range(99) >= 31);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    mqd_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_rsp_o), 0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_rsp_o.result_code !== want.result_code)
          report_mismatch("result_code", 32'(out_rsp_o.result_code), 32'(want.result_code));
        if (out_rsp_o.taken_id !== want.taken_id)
          report_mismatch("taken_id", 32'(out_rsp_o.taken_id), 32'(want.taken_id));
        if (out_rsp_o.queue_count !== want.queue_count)
          report_mismatch("queue_count", 32'(out_rsp_o.queue_count), 32'(want.queue_count));
      end
    end
  end

  // Offer one request beat; returns at the edge that accepted it, valid still high
  task automatic send_beat(input mqd_req_t req);
    if (tx_jitter) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp_q.push_back(deque_predict(req));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_fill_and_drain_last_queue();
    int unsigned q;
    q = NUM_Q - 1;
    send_beat(mk_req(MODE_ADD, q, 16'h0000, 1'b0));
    send_beat(mk_req(MODE_ADD, q, 16'hFFFF, 1'b0));
    send_beat(mk_req(MODE_ADD, q, 16'h1234, 1'b1));
    send_beat(mk_req(MODE_ADD, q, 16'hA5A5, 1'b0));
    send_beat(mk_req(MODE_ADD, q, 16'h5A5A, 1'b1));
    send_beat(mk_req(MODE_ADD, q, 16'h8001, 1'b0));
    send_beat(mk_req(MODE_ADD, q, 16'h7FFE, 1'b1));
    send_beat(mk_req(MODE_ADD, q, 16'h00FF, 1'b0));
    // queue now full: both kinds of add are rejected
    send_beat(mk_req(MODE_ADD, q, 16'hBEEF, 1'b0));
    send_beat(mk_req(MODE_ADD, q, 16'hCAFE, 1'b1));
    for (int i = 0; i < DEPTH; i++)
      send_beat(mk_req(MODE_TAKE, q, $urandom_range(16'hFFFF), i[0]));
    send_beat(mk_req(MODE_TAKE, q, 16'hFFFF, 1'b1));
  endtask

  task automatic test_urgent_wraparound_first_queue();
    // urgent add on an empty ring moves the head below slot zero
    send_beat(mk_req(MODE_ADD, 0, 16'hFFFF, 1'b1));
    send_beat(mk_req(MODE_ADD, 0, 16'h0001, 1'b0));
    send_beat(mk_req(MODE_TAKE, 0, 16'h0000, 1'b0));
    send_beat(mk_req(MODE_TAKE, 0, 16'h0000, 1'b0));
    send_beat(mk_req(MODE_TAKE, 0, 16'hFFFF, 1'b1));
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [QSEL_W-1:0] hot [4];
    int unsigned       add_pct;
    int unsigned       roll;
    mqd_req_t          req;
    add_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 75;
          1:       add_pct = 25;
          default: add_pct = 50;
        endcase
        if (i == 0 || $urandom_range(2) == 0)
          foreach (hot[k]) hot[k] = QSEL_W'($urandom_range(NUM_Q - 1));
      end
      roll             = $urandom_range(99);
      req.entry_id     = ENTRY_ID_W'($urandom_range(16'hFFFF));
      req.urgent       = 1'($urandom_range(1));
      if (roll < 10) begin
        // scattered noise over every queue
        req.mode         = 1'($urandom_range(1));
        req.queue_select = QSEL_W'($urandom_range(NUM_Q - 1));
      end else begin
        req.mode         = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_TAKE;
        req.queue_select = hot[2'($urandom_range(3))];
      end
      send_beat(req);
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    test_random_traffic(n_items);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  task automatic test_output_hold_off();
    int unsigned q;
    q = $urandom_range(NUM_Q - 1);
    wait_for_drain();
    hold_off_left = 150;
    tx_jitter     = 1'b0;
    for (int i = 0; i < 24; i++)
      send_beat(mk_req((i % 3 == 2) ? MODE_TAKE : MODE_ADD, q,
                       $urandom_range(16'hFFFF), 1'($urandom_range(1))));
    tx_jitter = 1'b1;
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_drain_last_queue();
    test_urgent_wraparound_first_queue();
    test_random_traffic(300);
    test_back_to_back(150);
    test_output_hold_off();
    test_random_traffic(250);
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("tb_multi_queue_deque_engine OK");
    else
      $display("tb_multi_queue_deque_engine NOT OK");
    $finish;
  end

endmodule
